@@ sv/bmpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants for the 24-bit bitmap to RGB565 stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_DATA,
        PH_PAD,
        PH_DONE
    } t_phase;

    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_BAD_SIG = 2'd1;
    localparam logic [1:0] KIND_BAD_FMT = 2'd2;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [31:0] BMP_PLANES    = 32'd1;
    localparam logic [31:0] BMP_BPP       = 32'd24;
    localparam logic [31:0] HEADER_LEN    = 32'd34;

    localparam logic [5:0] POS_SIG_END     = 6'd1;
    localparam logic [5:0] POS_OFFSET_END  = 6'd13;
    localparam logic [5:0] POS_WIDTH_END   = 6'd21;
    localparam logic [5:0] POS_HEIGHT_END  = 6'd25;
    localparam logic [5:0] POS_PLANES_END  = 6'd27;
    localparam logic [5:0] POS_BPP_END     = 6'd29;
    localparam logic [5:0] POS_HEADER_END  = 6'd33;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel;
        logic [15:0] column;
        logic [15:0] image_row;
        logic        last_pixel;
    } t_result;

endpackage

@@ sv/bmpd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_core
// Parser state and per-byte step logic: header fields, offset skip, pixel
// assembly, row padding and error detection.
// ----------------------------------------------------------------------------
module bmpd_core
    import bmpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_sof,
    input  logic [7:0]  i_byte,
    output logic        o_emit,
    output t_result     o_result
);

    t_phase      r_phase, n_phase, e_phase;
    logic [31:0] r_pos, n_pos, e_pos;
    logic [31:0] r_field, n_field;
    logic [31:0] r_offset, n_offset;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [15:0] r_col, n_col, e_col;
    logic [15:0] r_row, n_row, e_row;
    logic [1:0]  r_bip, n_bip, e_bip;
    logic [1:0]  r_pad, n_pad, e_pad;
    logic [7:0]  r_blue, n_blue;
    logic [7:0]  r_green, n_green;

    logic [1:0]  lane;
    logic        do_data;
    logic        row_end;
    logic        last;
    logic        rows_done;

    function automatic logic [1:0] f_lane(input logic [5:0] pos);
        logic [1:0] l;
        if (pos < 6'd2) begin
            l = pos[1:0];
        end else if (pos < 6'd26) begin
            l = pos[1:0] - 2'd2;
        end else if (pos < 6'd30) begin
            l = {1'b0, pos[0]};
        end else begin
            l = pos[1:0] - 2'd2;
        end
        return l;
    endfunction

    always_comb begin
        e_phase = i_sof ? PH_HEADER : r_phase;
        e_pos   = i_sof ? 32'd0 : r_pos;
        e_col   = i_sof ? 16'd0 : r_col;
        e_row   = i_sof ? 16'd0 : r_row;
        e_bip   = i_sof ? 2'd0 : r_bip;
        e_pad   = i_sof ? 2'd0 : r_pad;

        n_phase  = e_phase;
        n_pos    = e_pos;
        n_field  = r_field;
        n_offset = r_offset;
        n_width  = r_width;
        n_height = r_height;
        n_col    = e_col;
        n_row    = e_row;
        n_bip    = e_bip;
        n_pad    = e_pad;
        n_blue   = r_blue;
        n_green  = r_green;

        o_emit   = 1'b0;
        o_result = '0;

        lane      = f_lane(e_pos[5:0]);
        row_end   = ({1'b0, e_col} + 17'd1) >= {1'b0, r_width};
        last      = row_end && (({1'b0, e_row} + 17'd1) >= {1'b0, r_height});
        rows_done = ({1'b0, e_row} + 17'd1) >= {1'b0, r_height};
        do_data   = (e_phase == PH_DATA) ||
                    ((e_phase == PH_SKIP) && (e_pos == r_offset));

        if (e_phase == PH_HEADER) begin
            case (lane)
                2'd0:    n_field = {24'd0, i_byte};
                2'd1:    n_field = r_field | {16'd0, i_byte, 8'd0};
                2'd2:    n_field = r_field | {8'd0, i_byte, 16'd0};
                default: n_field = r_field | {i_byte, 24'd0};
            endcase
            n_pos = e_pos + 32'd1;
            case (e_pos[5:0])
                POS_SIG_END: begin
                    if (n_field != {16'd0, BMP_SIGNATURE}) begin
                        o_emit        = 1'b1;
                        o_result.kind = KIND_BAD_SIG;
                        n_phase       = PH_DONE;
                    end
                end
                POS_OFFSET_END: n_offset = n_field;
                POS_WIDTH_END:  n_width  = n_field[15:0];
                POS_HEIGHT_END: n_height = n_field[15:0];
                POS_PLANES_END: begin
                    if (n_field != BMP_PLANES) begin
                        o_emit        = 1'b1;
                        o_result.kind = KIND_BAD_FMT;
                        n_phase       = PH_DONE;
                    end
                end
                POS_BPP_END: begin
                    if (n_field != BMP_BPP) begin
                        o_emit        = 1'b1;
                        o_result.kind = KIND_BAD_FMT;
                        n_phase       = PH_DONE;
                    end
                end
                POS_HEADER_END: begin
                    if ((n_field != 32'd0) || (r_offset < HEADER_LEN)) begin
                        o_emit        = 1'b1;
                        o_result.kind = KIND_BAD_FMT;
                        n_phase       = PH_DONE;
                    end else if ((r_width == 16'd0) || (r_height == 16'd0)) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                default: ;
            endcase
        end else if ((e_phase == PH_SKIP) && !do_data) begin
            n_pos = e_pos + 32'd1;
        end else if (do_data) begin
            n_phase = PH_DATA;
            case (e_bip)
                2'd0: begin
                    n_blue = i_byte;
                    n_bip  = 2'd1;
                end
                2'd1: begin
                    n_green = i_byte;
                    n_bip   = 2'd2;
                end
                default: begin
                    n_bip               = 2'd0;
                    o_emit              = 1'b1;
                    o_result.kind       = KIND_PIXEL;
                    o_result.pixel      = {i_byte[7:3], r_green[7:2], r_blue[7:3]};
                    o_result.column     = e_col;
                    o_result.image_row  = r_height - 16'd1 - e_row;
                    o_result.last_pixel = last;
                    if (last) begin
                        n_phase = PH_DONE;
                    end else if (row_end) begin
                        n_pad = r_width[1:0];
                        n_col = 16'd0;
                        if (r_width[1:0] != 2'd0) begin
                            n_phase = PH_PAD;
                        end else begin
                            n_row   = e_row + 16'd1;
                            n_phase = rows_done ? PH_DONE : PH_DATA;
                        end
                    end else begin
                        n_col = e_col + 16'd1;
                    end
                end
            endcase
        end else if (e_phase == PH_PAD) begin
            n_pad = e_pad - 2'd1;
            if (n_pad == 2'd0) begin
                n_col   = 16'd0;
                n_row   = e_row + 16'd1;
                n_phase = rows_done ? PH_DONE : PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_bip   <= '0;
            r_pad   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_col   <= n_col;
            r_row   <= n_row;
            r_bip   <= n_bip;
            r_pad   <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_field  <= n_field;
            r_offset <= n_offset;
            r_width  <= n_width;
            r_height <= n_height;
            r_blue   <= n_blue;
            r_green  <= n_green;
        end
    end

    a_bip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bip != 2'd3)
        else $error("Byte-in-pixel counter reached an unused code.");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_sof && (r_phase == PH_DONE)) |=> (r_phase == PH_DONE))
        else $error("Parser left the done phase without a new file.");

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit && (o_result.kind != KIND_PIXEL)) |=> (r_phase == PH_DONE))
        else $error("Parser kept running after an error item.");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit && o_result.last_pixel) |=> (r_phase == PH_DONE))
        else $error("Parser kept running after the final pixel.");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_sof && (r_phase == PH_DONE)) |-> !o_emit)
        else $error("Parser produced an item in the done phase.");

endmodule

@@ sv/bmp24_stream_to_rgb565.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_stream_to_rgb565
// Streaming decoder for uncompressed 24-bit bitmap files, one byte per item,
// producing RGB565 pixels with their column and top-down row, or error items.
// ----------------------------------------------------------------------------
// Path: a taken byte waits in the input register; the single parser step
// between it and the output register writes any result there for o_out_valid.
// Throughput: one byte per cycle, unless a result waits on a stalled output.
// Reset: synchronous active-low reset returns the parser to the header phase
// and empties both registers; start_of_file restarts parsing at any time.
module bmp24_stream_to_rgb565
    import bmpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_of_file,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_pixel,
    output logic [15:0] o_column,
    output logic [15:0] o_image_row,
    output logic        o_last_pixel
);

    logic       r_in_valid;
    logic       r_sof;
    logic [7:0] r_byte;
    logic       r_out_valid;
    t_result    r_result;

    logic       emit;
    t_result    result;
    logic       out_free;
    logic       advance;

    bmpd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sof    (r_sof),
        .i_byte   (r_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (out_free || !emit);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sof  <= i_start_of_file;
            r_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_result <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_result.kind;
    assign o_pixel      = r_result.pixel;
    assign o_column     = r_result.column;
    assign o_image_row  = r_result.image_row;
    assign o_last_pixel = r_result.last_pixel;

endmodule

@@ tb/sv/bmp24_stream_to_rgb565_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_stream_to_rgb565_test
// Feeds whole and broken 24-bit bitmap files into the decoder one byte per
// item, with random gaps on the input and random stalls on the output. The
// bench decodes every accepted byte itself and compares each result from the
// block field by field, in order, with what it decoded.
// ----------------------------------------------------------------------------
module bmp24_stream_to_rgb565_test
    import bmpd_pkg::*;
();

    typedef struct {
        logic       sof;
        logic [7:0] data;
    } t_file_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_start_of_file = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [15:0] o_pixel;
    logic [15:0] o_column;
    logic [15:0] o_image_row;
    logic        o_last_pixel;

    t_file_byte  pending_bytes[$];
    t_result     decoded_items[$];
    int          mismatch_count = 0;
    int          idle_left = 0;
    int          stall_left = 0;
    logic        in_taken = 1'b0;
    logic        calm = 1'b0;

    t_phase      dec_phase;
    logic [31:0] hdr_pos;
    logic [31:0] field_value;
    logic [31:0] data_start;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [15:0] col_idx;
    logic [15:0] row_idx;
    logic [1:0]  pix_byte;
    logic [1:0]  pad_left;
    logic [7:0]  blue_byte;
    logic [7:0]  green_byte;

    bmp24_stream_to_rgb565 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_of_file (i_start_of_file),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_pixel         (o_pixel),
        .o_column        (o_column),
        .o_image_row     (o_image_row),
        .o_last_pixel    (o_last_pixel)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    task automatic clear_decoder();
        dec_phase   = PH_HEADER;
        hdr_pos     = '0;
        field_value = '0;
        data_start  = '0;
        img_w       = '0;
        img_h       = '0;
        col_idx     = '0;
        row_idx     = '0;
        pix_byte    = '0;
        pad_left    = '0;
        blue_byte   = '0;
        green_byte  = '0;
    endtask

    task automatic flag_error(input logic [1:0] kind);
        t_result r;
        r = '0;
        r.kind = kind;
        decoded_items.push_back(r);
        dec_phase = PH_DONE;
    endtask

    task automatic advance_row();
        col_idx   = '0;
        row_idx   = row_idx + 16'd1;
        dec_phase = (row_idx >= img_h) ? PH_DONE : PH_DATA;
    endtask

    task automatic decode_byte(input logic sof, input logic [7:0] b);
        logic [31:0] p;
        logic [31:0] base;
        t_result     r;
        logic        row_end;
        logic        last;
        if (sof) begin
            clear_decoder();
        end
        if (dec_phase == PH_HEADER) begin
            p = hdr_pos;
            if (p < 2) base = 0;
            else if (p < 26) base = 2 + ((p - 2) / 4) * 4;
            else if (p < 30) base = 26 + ((p - 26) / 2) * 2;
            else base = 30;
            if (p == base) field_value = 32'(b);
            else field_value = field_value | (32'(b) << ((p - base) * 8));
            hdr_pos = p + 1;
            case (p)
                POS_SIG_END: begin
                    if (field_value != 32'(BMP_SIGNATURE)) flag_error(KIND_BAD_SIG);
                end
                POS_OFFSET_END: data_start = field_value;
                POS_WIDTH_END: img_w = field_value[15:0];
                POS_HEIGHT_END: img_h = field_value[15:0];
                POS_PLANES_END: begin
                    if (field_value != BMP_PLANES) flag_error(KIND_BAD_FMT);
                end
                POS_BPP_END: begin
                    if (field_value != BMP_BPP) flag_error(KIND_BAD_FMT);
                end
                POS_HEADER_END: begin
                    if (field_value != 0 || data_start < HEADER_LEN) begin
                        flag_error(KIND_BAD_FMT);
                    end else if (img_w == 0 || img_h == 0) begin
                        dec_phase = PH_DONE;
                    end else begin
                        dec_phase = PH_SKIP;
                    end
                end
                default: ;
            endcase
            return;
        end
        if (dec_phase == PH_SKIP) begin
            if (hdr_pos != data_start) begin
                hdr_pos = hdr_pos + 1;
                return;
            end
            dec_phase = PH_DATA;
        end
        if (dec_phase == PH_DATA) begin
            if (pix_byte == 2'd0) begin
                blue_byte = b;
                pix_byte  = 2'd1;
                return;
            end
            if (pix_byte == 2'd1) begin
                green_byte = b;
                pix_byte   = 2'd2;
                return;
            end
            pix_byte = 2'd0;
            row_end = (32'(col_idx) + 32'd1) >= 32'(img_w);
            last = row_end && ((32'(row_idx) + 32'd1) >= 32'(img_h));
            r.kind       = KIND_PIXEL;
            r.pixel      = {b[7:3], green_byte[7:2], blue_byte[7:3]};
            r.column     = col_idx;
            r.image_row  = img_h - 16'd1 - row_idx;
            r.last_pixel = last;
            decoded_items.push_back(r);
            if (last) begin
                dec_phase = PH_DONE;
            end else if (row_end) begin
                pad_left = img_w[1:0];
                if (pad_left != 2'd0) begin
                    col_idx   = '0;
                    dec_phase = PH_PAD;
                end else begin
                    advance_row();
                end
            end else begin
                col_idx = col_idx + 16'd1;
            end
            return;
        end
        if (dec_phase == PH_PAD) begin
            pad_left = pad_left - 2'd1;
            if (pad_left == 2'd0) advance_row();
        end
    endtask

    // A negative total sends the whole file plus a few trailing bytes; a
    // negative fill gives random pixel and padding bytes.
    task automatic queue_bmp(input logic with_sof, input logic [15:0] sig,
                             input logic [31:0] offs, input logic [31:0] w,
                             input logic [31:0] h, input logic [15:0] planes,
                             input logic [15:0] bpp, input logic [31:0] comp,
                             input int total, input int fill);
        logic [7:0] hdr[0:33];
        int         body;
        int         w16;
        int         h16;
        int         len;
        t_file_byte fb;
        for (int k = 0; k < 34; k++) hdr[k] = 8'($urandom);
        {hdr[1], hdr[0]} = sig;
        {hdr[13], hdr[12], hdr[11], hdr[10]} = offs;
        {hdr[21], hdr[20], hdr[19], hdr[18]} = w;
        {hdr[25], hdr[24], hdr[23], hdr[22]} = h;
        {hdr[27], hdr[26]} = planes;
        {hdr[29], hdr[28]} = bpp;
        {hdr[33], hdr[32], hdr[31], hdr[30]} = comp;
        w16 = int'(w[15:0]);
        h16 = int'(h[15:0]);
        if (w16 == 0 || h16 == 0) body = 0;
        else body = int'(offs) - 34 + h16 * (3 * w16 + (w16 % 4));
        if (body < 0) body = 0;
        len = (total < 0) ? 34 + body + $urandom_range(0, 3) : total;
        for (int k = 0; k < len; k++) begin
            fb.sof = with_sof && (k == 0);
            if (k < 34) fb.data = hdr[k];
            else fb.data = (fill < 0) ? 8'($urandom) : 8'(fill);
            pending_bytes.push_back(fb);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) calm <= ~calm;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (idle_left != 0) begin
                i_in_valid <= 1'b0;
                idle_left  <= idle_left - 1;
            end else if (pending_bytes.size() != 0) begin
                i_start_of_file <= pending_bytes[0].sof;
                i_data_byte     <= pending_bytes[0].data;
                void'(pending_bytes.pop_front());
                i_in_valid      <= 1'b1;
                idle_left       <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            stall_left  <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            clear_decoder();
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) decode_byte(i_start_of_file, i_data_byte);
            if (o_out_valid && i_out_ready) begin
                if (decoded_items.size() == 0) begin
                    report_mismatch($sformatf("result with none expected, kind %0d pixel %h",
                                              o_kind, o_pixel));
                end else begin
                    if (o_kind !== decoded_items[0].kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  o_kind, decoded_items[0].kind));
                    if (o_pixel !== decoded_items[0].pixel)
                        report_mismatch($sformatf("pixel %h, expected %h",
                                                  o_pixel, decoded_items[0].pixel));
                    if (o_column !== decoded_items[0].column)
                        report_mismatch($sformatf("column %0d, expected %0d",
                                                  o_column, decoded_items[0].column));
                    if (o_image_row !== decoded_items[0].image_row)
                        report_mismatch($sformatf("image_row %0d, expected %0d",
                                                  o_image_row, decoded_items[0].image_row));
                    if (o_last_pixel !== decoded_items[0].last_pixel)
                        report_mismatch($sformatf("last_pixel %0d, expected %0d",
                                                  o_last_pixel, decoded_items[0].last_pixel));
                    void'(decoded_items.pop_front());
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("bmp24_stream_to_rgb565_test failed");
        $finish;
    end

    initial begin
        int          r;
        int          n;
        int          drain;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] offs;
        logic [31:0] comp;
        logic [15:0] sig;
        logic [15:0] planes;
        logic [15:0] bpp;
        t_file_byte  fb;

        queue_bmp(1'b0, BMP_SIGNATURE, 34, 2, 2, 1, 24, 0, -1, -1);
        queue_bmp(1'b1, 16'hCD42, 34, 1, 1, 1, 24, 0, 5, -1);
        queue_bmp(1'b1, BMP_SIGNATURE, 34, 1, 1, 16'h0101, 24, 0, 30, -1);
        queue_bmp(1'b1, BMP_SIGNATURE, 34, 1, 1, 1, 24, 32'h8000_0000, 36, -1);
        queue_bmp(1'b1, BMP_SIGNATURE, 33, 1, 1, 1, 24, 0, 36, -1);
        queue_bmp(1'b1, BMP_SIGNATURE, 34, 0, 3, 1, 24, 0, 40, -1);
        queue_bmp(1'b1, BMP_SIGNATURE, 34, 3, 0, 1, 24, 0, 40, -1);
        queue_bmp(1'b1, BMP_SIGNATURE, 34, 4, 1, 1, 24, 0, -1, 255);
        queue_bmp(1'b1, BMP_SIGNATURE, 34, 32'hFFFF_0003, 32'h8000_0002, 1, 24, 0, -1, -1);
        queue_bmp(1'b1, BMP_SIGNATURE, 34, 1, 16'hFFFF, 1, 24, 0, 43, -1);
        queue_bmp(1'b1, BMP_SIGNATURE, 34, 16'hFFFF, 1, 1, 24, 0, 46, -1);
        queue_bmp(1'b1, BMP_SIGNATURE, 32'hFFFF_FFFF, 2, 2, 1, 24, 0, 40, -1);

        while (pending_bytes.size() < 700) begin
            r = $urandom_range(0, 99);
            w = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) w = {16'($urandom), 16'($urandom_range(0, 7))};
            h = $urandom_range(1, 4);
            offs = 34 + $urandom_range(0, 6);
            sig = BMP_SIGNATURE;
            planes = 16'(BMP_PLANES);
            bpp = 16'(BMP_BPP);
            comp = 0;
            if (r < 65) begin
                queue_bmp(1'b1, sig, offs, w, h, planes, bpp, comp, -1, -1);
            end else if (r < 73) begin
                queue_bmp(1'b1, sig, offs, w, h, planes, bpp, comp,
                          $urandom_range(1, 74), -1);
            end else if (r < 81) begin
                sig = sig ^ (16'd1 << $urandom_range(0, 15));
                queue_bmp(1'b1, sig, offs, w, h, planes, bpp, comp,
                          $urandom_range(2, 40), -1);
            end else if (r < 91) begin
                case ($urandom_range(0, 3))
                    0: planes = (planes == 16'($urandom)) ? 16'd0 : 16'($urandom);
                    1: bpp = 16'($urandom_range(0, 48)) ^ 16'(1 << $urandom_range(0, 15));
                    2: comp = 32'($urandom) | (32'd1 << $urandom_range(0, 31));
                    default: offs = $urandom_range(0, 33);
                endcase
                if (planes == 16'(BMP_PLANES) && bpp == 16'(BMP_BPP)
                    && comp == 0 && offs >= HEADER_LEN) begin
                    planes = 16'd2;
                end
                queue_bmp(1'b1, sig, offs, w, h, planes, bpp, comp,
                          34 + $urandom_range(0, 10), -1);
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    fb.sof  = ($urandom_range(0, 9) == 0);
                    fb.data = 8'($urandom);
                    pending_bytes.push_back(fb);
                end
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        drain = 0;
        while (decoded_items.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        if (decoded_items.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      decoded_items.size()));
        end
        if (mismatch_count == 0) begin
            $display("bmp24_stream_to_rgb565_test passed");
        end else begin
            $display("bmp24_stream_to_rgb565_test failed");
        end
        $finish;
    end

endmodule

@@ bmp24_stream_to_rgb565.f @@
sv/bmpd_pkg.sv
sv/bmpd_core.sv
sv/bmp24_stream_to_rgb565.sv
tb/sv/bmp24_stream_to_rgb565_test.sv
